// ===== rtl/lesf_pkg.sv =====
// ----------------------------------------------------------------------------
// lesf_pkg: shared constants, types and helpers
// Sizes, register indexes and the cell operation handed from the front
// end to the back end of the largest empty square finder.
// ----------------------------------------------------------------------------
`default_nettype none

package lesf_pkg;

	// Grid limits
	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;

	// Field widths
	localparam int CHAR_W = 8;
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int LEN_W  = $clog2(MAX_COLS + 1);
	localparam int SIZE_W = $clog2(MAX_COLS + 1);

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LEN_W;

	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_CHAR    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_CHAR = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH    = CFG_IDX_W'(2);

	localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST = CHAR_W'(46);
	localparam logic [LEN_W-1:0]  ROW_LENGTH_RST = LEN_W'(MAX_COLS);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One classified cell
	typedef struct packed {
		logic             is_empty;   // cell code matches the empty code
		logic             first;      // first row or first column
		logic             wrap;       // last cell of its row
		logic             last;       // last cell of the map
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} cell_op_t;

	// Smallest of three square sizes
	function automatic logic [SIZE_W-1:0] min3(
		input logic [SIZE_W-1:0] a,
		input logic [SIZE_W-1:0] b,
		input logic [SIZE_W-1:0] c
	);
		logic [SIZE_W-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lesf_cell_if.sv =====
// ----------------------------------------------------------------------------
// lesf_cell_if: grid cell channel
// Valid/ready channel that carries one grid cell per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lesf_cell_if;
	logic                        valid;
	logic                        ready;
	logic [lesf_pkg::CHAR_W-1:0] cell_char;
	logic                        last_in_map;

	modport source (output valid, output cell_char, output last_in_map, input ready);
	modport sink   (input valid, input cell_char, input last_in_map, output ready);
endinterface

`default_nettype wire

// ===== rtl/lesf_result_if.sv =====
// ----------------------------------------------------------------------------
// lesf_result_if: square result channel
// Valid/ready channel that carries one largest-square result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lesf_result_if;
	logic                        valid;
	logic                        ready;
	logic [lesf_pkg::SIZE_W-1:0] square_size;
	logic [lesf_pkg::ROW_W-1:0]  bottom_row;
	logic [lesf_pkg::COL_W-1:0]  right_col;

	modport source (output valid, output square_size, output bottom_row, output right_col,
		input ready);
	modport sink   (input valid, input square_size, input bottom_row, input right_col,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/lesf_ram.sv =====
// ----------------------------------------------------------------------------
// lesf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lesf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]                              wdata,
	input  wire logic                                          re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic      [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/lesf_front.sv =====
// ----------------------------------------------------------------------------
// lesf_front: configuration and cell classification
// Holds the configuration registers, tracks the scan position and turns
// each accepted cell beat into a cell operation for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lesf_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [lesf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lesf_pkg::CFG_DATA_W-1:0]     cfg_data,
	lesf_cell_if.sink                                cells,
	input  wire logic                                q_full,
	output logic                                     q_push,
	output lesf_pkg::cell_op_t                       q_op
);

	logic [lesf_pkg::CHAR_W-1:0] empty_char_q;
	logic [lesf_pkg::LEN_W-1:0]  row_length_q;
	logic [lesf_pkg::COL_W-1:0]  col_q;
	logic [lesf_pkg::ROW_W-1:0]  row_q;

	logic [lesf_pkg::LEN_W-1:0]  eff_len;
	logic [lesf_pkg::LEN_W-1:0]  col_inc;
	logic                        wrap;
	logic                        accept;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_char_q <= lesf_pkg::EMPTY_CHAR_RST;
			row_length_q <= lesf_pkg::ROW_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lesf_pkg::CFG_EMPTY_CHAR: empty_char_q <= cfg_data[lesf_pkg::CHAR_W-1:0];
				// any code other than the empty code is an obstacle
				lesf_pkg::CFG_OBSTACLE_CHAR: ;
				lesf_pkg::CFG_ROW_LENGTH: row_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp row length into 1..MAX_COLS
	always_comb begin
		if (row_length_q == '0) begin
			eff_len = lesf_pkg::LEN_W'(1);
		end else if (row_length_q > lesf_pkg::LEN_W'(lesf_pkg::MAX_COLS)) begin
			eff_len = lesf_pkg::LEN_W'(lesf_pkg::MAX_COLS);
		end else begin
			eff_len = row_length_q;
		end
	end

	assign col_inc = lesf_pkg::LEN_W'(col_q) + lesf_pkg::LEN_W'(1);
	assign wrap    = (col_inc >= eff_len);

	assign cells.ready = !q_full;
	assign accept      = cells.valid && !q_full;
	assign q_push      = accept;

	// Classify the cell
	always_comb begin
		q_op          = '0;
		q_op.is_empty = (cells.cell_char == empty_char_q);
		q_op.first    = (row_q == '0) || (col_q == '0);
		q_op.wrap     = wrap;
		q_op.last     = cells.last_in_map;
		q_op.col      = col_q;
		q_op.row      = row_q;
	end

	// Advance the scan position; restart after the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (cells.last_in_map) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				if (row_q < lesf_pkg::ROW_W'(lesf_pkg::MAX_ROWS - 1)) begin
					row_q <= row_q + lesf_pkg::ROW_W'(1);
				end
			end else begin
				col_q <= col_inc[lesf_pkg::COL_W-1:0];
			end
		end
	end

	// A finished map leaves the position at the origin
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cells.last_in_map |=> col_q == '0 && row_q == '0)
		else $error("scan position not cleared after last cell");

endmodule

`default_nettype wire

// ===== rtl/lesf_queue.sv =====
// ----------------------------------------------------------------------------
// lesf_queue: cell operation queue
// Short FIFO that decouples the classifying front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lesf_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire lesf_pkg::cell_op_t push_op,
	output logic                    full,
	input  wire logic               pop,
	output lesf_pkg::cell_op_t      head_op,
	output logic                    not_empty
);

	lesf_pkg::cell_op_t               entries_q [lesf_pkg::QUEUE_DEPTH];
	logic [lesf_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [lesf_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [lesf_pkg::QCNT_W-1:0]      count_q;

	assign full      = (count_q == lesf_pkg::QCNT_W'(lesf_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_op   = entries_q[rd_ptr_q];

	// Store pushed operations
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == lesf_pkg::QPTR_W'(lesf_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + lesf_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == lesf_pkg::QPTR_W'(lesf_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + lesf_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + lesf_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - lesf_pkg::QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lesf_pkg::QCNT_W'(lesf_pkg::QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/lesf_back.sv =====
// ----------------------------------------------------------------------------
// lesf_back: square size engine
// Reads the line store, computes each cell's square size, keeps the running
// best and registers the result beat at the end of each map.
// ----------------------------------------------------------------------------
`default_nettype none

module lesf_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire lesf_pkg::cell_op_t q_op,
	output logic                    q_pop,
	lesf_result_if.source           result
);

	lesf_pkg::cell_op_t            op_s2;
	logic                          valid_s2;

	logic [lesf_pkg::SIZE_W-1:0]   left_q;
	logic [lesf_pkg::SIZE_W-1:0]   diag_q;
	logic [lesf_pkg::SIZE_W-1:0]   best_size_q;
	logic [lesf_pkg::ROW_W-1:0]    best_row_q;
	logic [lesf_pkg::COL_W-1:0]    best_col_q;

	logic                          result_valid_q;
	logic [lesf_pkg::SIZE_W-1:0]   result_size_q;
	logic [lesf_pkg::ROW_W-1:0]    result_row_q;
	logic [lesf_pkg::COL_W-1:0]    result_col_q;

	logic [lesf_pkg::SIZE_W-1:0]   top;
	logic [lesf_pkg::SIZE_W-1:0]   nbr_min;
	logic [lesf_pkg::SIZE_W:0]     grown;
	logic [lesf_pkg::SIZE_W-1:0]   size;
	logic                          better;
	logic                          hold_s2;
	logic                          fire_s2;
	logic                          take_s2;

	// Line of square sizes from the previous row
	lesf_ram #(
		.WIDTH (lesf_pkg::SIZE_W),
		.DEPTH (lesf_pkg::MAX_COLS)
	) u_line (
		.clk   (clk),
		.we    (fire_s2),
		.waddr (op_s2.col),
		.wdata (size),
		.re    (q_pop),
		.raddr (q_op.col),
		.rdata (top)
	);

	// Stall only a last cell while the previous result is still waiting
	assign hold_s2 = valid_s2 && op_s2.last && result_valid_q && !result.ready;
	assign fire_s2 = valid_s2 && !hold_s2;
	assign take_s2 = !valid_s2 || fire_s2;
	assign q_pop   = q_valid && take_s2;

	// Square size of the cell in stage 2
	assign nbr_min = lesf_pkg::min3(top, diag_q, left_q);
	assign grown   = {1'b0, nbr_min} + (lesf_pkg::SIZE_W + 1)'(1);

	always_comb begin
		if (!op_s2.is_empty) begin
			size = '0;
		end else if (op_s2.first) begin
			size = lesf_pkg::SIZE_W'(1);
		end else if (grown[lesf_pkg::SIZE_W]) begin
			size = '1;
		end else begin
			size = grown[lesf_pkg::SIZE_W-1:0];
		end
	end

	assign better = (size > best_size_q);

	// Move the queue head into stage 2 alongside its line read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_s2) begin
			valid_s2 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s2 <= q_op;
		end
	end

	// Update neighbor sizes and running best; clear after the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			diag_q      <= '0;
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else if (fire_s2) begin
			if (op_s2.last) begin
				left_q      <= '0;
				diag_q      <= '0;
				best_size_q <= '0;
				best_row_q  <= '0;
				best_col_q  <= '0;
			end else begin
				left_q <= op_s2.wrap ? '0 : size;
				diag_q <= op_s2.wrap ? '0 : top;
				if (better) begin
					best_size_q <= size;
					best_row_q  <= op_s2.row;
					best_col_q  <= op_s2.col;
				end
			end
		end
	end

	// Result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire_s2 && op_s2.last) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s2 && op_s2.last) begin
			result_size_q <= better ? size : best_size_q;
			result_row_q  <= better ? op_s2.row : best_row_q;
			result_col_q  <= better ? op_s2.col : best_col_q;
		end
	end

	assign result.valid       = result_valid_q;
	assign result.square_size = result_size_q;
	assign result.bottom_row  = result_row_q;
	assign result.right_col   = result_col_q;

	a_map_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s2 && op_s2.last |=> best_size_q == '0 && left_q == '0 && diag_q == '0)
		else $error("scan state not cleared after last cell");

	a_best_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s2 && !op_s2.last |=> best_size_q >= $past(best_size_q))
		else $error("running best decreased within a map");

	a_pop_lands: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> valid_s2)
		else $error("popped cell lost before stage 2");

endmodule

`default_nettype wire

// ===== rtl/largest_empty_square_finder.sv =====
// ----------------------------------------------------------------------------
// largest_empty_square_finder: maximal-square search over a streamed grid
// Classifies streamed grid cells, runs the maximal-square recurrence over
// one stored line of sizes and reports the largest empty square per map.
//
//   Port       Dir  Handshake     Beat contents
//   cells      in   valid/ready   cell_char, last_in_map
//   result     out  valid/ready   square_size, bottom_row, right_col
//   cfg_*      in   write enable  cfg_index, cfg_data (no read-back)
//
// One cell per cycle sustained; the line store read/write pair and the
// three-way minimum share one stage. A result is registered once its last
// cell leaves stage 2. Reset is asynchronous and needs no clearing pass.
// Cells keep flowing while a result waits; only a map's last cell stalls,
// behind an untaken result, and the two-entry queue then fills.
// ----------------------------------------------------------------------------
`default_nettype none

module largest_empty_square_finder (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [lesf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lesf_pkg::CFG_DATA_W-1:0]  cfg_data,
	lesf_cell_if.sink                             cells,
	lesf_result_if.source                         result
);

	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_not_empty;
	lesf_pkg::cell_op_t push_op;
	lesf_pkg::cell_op_t head_op;

	// Classify incoming cells
	lesf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cells     (cells),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_op      (push_op)
	);

	// Decouple front and back
	lesf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_op   (push_op),
		.full      (q_full),
		.pop       (q_pop),
		.head_op   (head_op),
		.not_empty (q_not_empty)
	);

	// Compute sizes and track the best square
	lesf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_not_empty),
		.q_op    (head_op),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule

`default_nettype wire
